// File: design/itp_pkg.sv
// ============================================================================
// itp_pkg: shared definitions for the infix to postfix converter
// Character codes, operator codes, controller/datapath command and status
// types, and small helper functions used by the datapath.
// ============================================================================
package itp_pkg;

    // Operator stack geometry.
    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    // ASCII characters with a meaning of their own.
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Status codes carried on the end marker.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNMATCHED = 2'd1;
    localparam logic [1:0] ST_UNCLOSED  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    // Codes held in the operator stack.
    typedef enum logic [2:0] {
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_OPEN = 3'd5
    } op_code_t;

    // Class of the character under work.
    typedef enum logic [2:0] {
        CLS_OPERAND,
        CLS_SPACE,
        CLS_OPER,
        CLS_OPEN,
        CLS_CLOSE
    } char_class_t;

    // Source of a new result.
    typedef enum logic [2:0] {
        EM_NONE,
        EM_CHAR,
        EM_SPACE,
        EM_POP,
        EM_END
    } emit_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      latch;
        logic      set_err;
        emit_sel_t emit;
        logic      push;
        logic      drop;
        logic      reset_state;
        logic      flush_pend;
    } itp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        char_class_t cls;
        logic        last;
        logic        err_active;
        logic        pred_err;
        logic        in_operand;
        logic        stack_empty;
        logic        pop_ok;
        logic        can_emit;
        logic        flush_ok;
    } itp_status_t;

    // Character that an operator code stands for.
    function automatic logic [7:0] op_char(input op_code_t code);
        logic [7:0] ch;
        unique case (code)
            OP_ADD:  ch = CH_ADD;
            OP_SUB:  ch = CH_SUB;
            OP_MUL:  ch = CH_MUL;
            OP_DIV:  ch = CH_DIV;
            OP_OPEN: ch = CH_OPEN;
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

    // Multiply and divide bind tighter than add and subtract.
    function automatic logic is_high(input op_code_t code);
        return (code == OP_MUL) || (code == OP_DIV);
    endfunction

endpackage

// File: design/itp_in_if.sv
// ============================================================================
// itp_in_if: input channel of the infix to postfix converter
// Carries one expression character per transaction with its end flag.
// ============================================================================
interface itp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       is_last;

    modport source (output valid, output in_char, output is_last, input ready);
    modport sink   (input valid, input in_char, input is_last, output ready);
endinterface

// File: design/itp_out_if.sv
// ============================================================================
// itp_out_if: output channel of the infix to postfix converter
// Carries one postfix character or end marker per transaction.
// ============================================================================
interface itp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_of_run;
    logic       expr_end;
    logic [1:0] status;

    modport source (output valid, output out_char, output last_of_run,
                    output expr_end, output status, input ready);
    modport sink   (input valid, input out_char, input last_of_run,
                    input expr_end, input status, output ready);
endinterface

// File: design/itp_datapath.sv
// ============================================================================
// itp_datapath: operator stack, expression state and result registers
// Holds the character under work, the operator stack with its counters, the
// error state, a one-deep pending result and the output register.
// ============================================================================
module itp_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          in_char,
    input  logic                is_last,
    input  itp_pkg::itp_cmd_t   cmd,
    output itp_pkg::itp_status_t status,
    itp_out_if.source           out_ch
);

    // Character under work.
    logic [7:0] char_reg;
    logic       last_reg;

    // Expression state.
    itp_pkg::op_code_t        op_stack_mem [itp_pkg::DEPTH];
    logic [itp_pkg::CNT_W-1:0] stack_count_reg, stack_count_next;
    logic [itp_pkg::CNT_W-1:0] open_count_reg, open_count_next;
    logic                      in_operand_reg, in_operand_next;
    logic [1:0]                error_reg, error_next;

    // Pending result and output register.
    logic       pend_valid_reg, pend_valid_next;
    logic [7:0] pend_char_reg;
    logic       pend_end_reg;
    logic [1:0] pend_status_reg;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg;
    logic       out_last_reg;
    logic       out_end_reg;
    logic [1:0] out_status_reg;

    // Combinational helpers.
    itp_pkg::char_class_t      cls;
    itp_pkg::op_code_t         cur_code;
    itp_pkg::op_code_t         top_code;
    logic [itp_pkg::CNT_W-1:0] count_m1;
    logic [itp_pkg::IDX_W-1:0] top_idx;
    logic                      stack_full;
    logic                      top_is_open;
    logic                      prec_ok;
    logic                      unclosed;
    logic [1:0]                pred_code;
    logic [7:0]                new_char;
    logic                      new_end;
    logic [1:0]                new_status;
    logic                      emit;
    logic                      out_free;
    logic                      move;

    // Classify the latched character and find its operator code.
    always_comb
    begin
        unique case (char_reg)
            itp_pkg::CH_ADD:   begin cls = itp_pkg::CLS_OPER;    cur_code = itp_pkg::OP_ADD;  end
            itp_pkg::CH_SUB:   begin cls = itp_pkg::CLS_OPER;    cur_code = itp_pkg::OP_SUB;  end
            itp_pkg::CH_MUL:   begin cls = itp_pkg::CLS_OPER;    cur_code = itp_pkg::OP_MUL;  end
            itp_pkg::CH_DIV:   begin cls = itp_pkg::CLS_OPER;    cur_code = itp_pkg::OP_DIV;  end
            itp_pkg::CH_OPEN:  begin cls = itp_pkg::CLS_OPEN;    cur_code = itp_pkg::OP_OPEN; end
            itp_pkg::CH_CLOSE: begin cls = itp_pkg::CLS_CLOSE;   cur_code = itp_pkg::OP_OPEN; end
            itp_pkg::CH_SPACE: begin cls = itp_pkg::CLS_SPACE;   cur_code = itp_pkg::OP_ADD;  end
            default:           begin cls = itp_pkg::CLS_OPERAND; cur_code = itp_pkg::OP_ADD;  end
        endcase
    end

    // Top of stack and the pop condition.
    assign count_m1    = stack_count_reg - itp_pkg::CNT_W'(1);
    assign top_idx     = count_m1[itp_pkg::IDX_W-1:0];
    assign top_code    = op_stack_mem[top_idx];
    assign stack_full  = (stack_count_reg == itp_pkg::CNT_W'(itp_pkg::DEPTH));
    assign top_is_open = (top_code == itp_pkg::OP_OPEN);
    assign prec_ok     = itp_pkg::is_high(top_code) || !itp_pkg::is_high(cur_code);

    // Errors that this character will raise, known before any result leaves.
    always_comb
    begin
        unique case (cls)
            itp_pkg::CLS_OPEN:  unclosed = 1'b1;
            itp_pkg::CLS_CLOSE: unclosed = (open_count_reg != itp_pkg::CNT_W'(1));
            default:            unclosed = (open_count_reg != '0);
        endcase
        pred_code = itp_pkg::ST_OK;
        priority if (cls == itp_pkg::CLS_OPER && stack_full && (top_is_open || !prec_ok))
            pred_code = itp_pkg::ST_OVERFLOW;
        else if (cls == itp_pkg::CLS_OPEN && stack_full)
            pred_code = itp_pkg::ST_OVERFLOW;
        else if (cls == itp_pkg::CLS_CLOSE && open_count_reg == '0)
            pred_code = itp_pkg::ST_UNMATCHED;
        else if (last_reg && unclosed)
            pred_code = itp_pkg::ST_UNCLOSED;
        else
            pred_code = itp_pkg::ST_OK;
    end

    // New result selected by the controller.
    always_comb
    begin
        new_end    = 1'b0;
        new_status = itp_pkg::ST_OK;
        unique case (cmd.emit)
            itp_pkg::EM_CHAR:  new_char = char_reg;
            itp_pkg::EM_SPACE: new_char = itp_pkg::CH_SPACE;
            itp_pkg::EM_POP:   new_char = itp_pkg::op_char(top_code);
            itp_pkg::EM_END:
            begin
                new_char   = itp_pkg::CH_NUL;
                new_end    = 1'b1;
                new_status = error_reg;
            end
            default:           new_char = itp_pkg::CH_NUL;
        endcase
    end

    assign emit     = (cmd.emit != itp_pkg::EM_NONE);
    assign out_free = !out_valid_reg || out_ch.ready;
    assign move     = pend_valid_reg && (emit || cmd.flush_pend);

    // Status towards the controller.
    assign status.cls         = cls;
    assign status.last        = last_reg;
    assign status.err_active  = (error_reg != itp_pkg::ST_OK);
    assign status.pred_err    = (pred_code != itp_pkg::ST_OK);
    assign status.in_operand  = in_operand_reg;
    assign status.stack_empty = (stack_count_reg == '0);
    assign status.pop_ok      = (stack_count_reg != '0) && !top_is_open &&
                                ((cls != itp_pkg::CLS_OPER) || prec_ok);
    assign status.can_emit    = !pend_valid_reg || out_free;
    assign status.flush_ok    = !pend_valid_reg || out_free;

    // Next values of the expression state.
    always_comb
    begin
        stack_count_next = stack_count_reg;
        open_count_next  = open_count_reg;
        in_operand_next  = in_operand_reg;
        error_next       = error_reg;
        if (cmd.emit == itp_pkg::EM_CHAR)
            in_operand_next = 1'b1;
        else if (cmd.emit == itp_pkg::EM_SPACE)
            in_operand_next = 1'b0;
        priority if (cmd.emit == itp_pkg::EM_POP)
            stack_count_next = count_m1;
        else if (cmd.push)
        begin
            stack_count_next = stack_count_reg + itp_pkg::CNT_W'(1);
            if (cur_code == itp_pkg::OP_OPEN)
                open_count_next = open_count_reg + itp_pkg::CNT_W'(1);
        end
        else if (cmd.drop)
        begin
            stack_count_next = count_m1;
            open_count_next  = open_count_reg - itp_pkg::CNT_W'(1);
        end
        if (cmd.set_err && error_reg == itp_pkg::ST_OK)
            error_next = pred_code;
        if (cmd.reset_state)
        begin
            stack_count_next = '0;
            open_count_next  = '0;
            in_operand_next  = 1'b0;
            error_next       = itp_pkg::ST_OK;
        end
    end

    // Next values of the pending and output valid flags.
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (emit)
            pend_valid_next = 1'b1;
        else if (cmd.flush_pend)
            pend_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (move)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_count_reg <= '0;
            open_count_reg  <= '0;
            in_operand_reg  <= 1'b0;
            error_reg       <= itp_pkg::ST_OK;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stack_count_reg <= stack_count_next;
            open_count_reg  <= open_count_next;
            in_operand_reg  <= in_operand_next;
            error_reg       <= error_next;
            pend_valid_reg  <= pend_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers and the operator stack.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            char_reg <= in_char;
            last_reg <= is_last;
        end
        if (cmd.push)
            op_stack_mem[stack_count_reg[itp_pkg::IDX_W-1:0]] <= cur_code;
        if (emit)
        begin
            pend_char_reg   <= new_char;
            pend_end_reg    <= new_end;
            pend_status_reg <= new_status;
        end
        if (move)
        begin
            out_char_reg   <= pend_char_reg;
            out_last_reg   <= cmd.flush_pend;
            out_end_reg    <= pend_end_reg;
            out_status_reg <= pend_status_reg;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_char    = out_char_reg;
    assign out_ch.last_of_run = out_last_reg;
    assign out_ch.expr_end    = out_end_reg;
    assign out_ch.status      = out_status_reg;

    // The stack never holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        stack_count_reg <= itp_pkg::CNT_W'(itp_pkg::DEPTH))
        else $error("operator stack count beyond depth");

    // Open parentheses are a subset of the stack entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        open_count_reg <= stack_count_reg)
        else $error("open parenthesis count exceeds stack count");

    // A pop is only requested on a non-empty stack.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit == itp_pkg::EM_POP |-> stack_count_reg != '0)
        else $error("pop from an empty operator stack");

    // The end marker closes its run, carries a zero character and clears the state.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_end_reg |-> out_last_reg && out_char_reg == itp_pkg::CH_NUL)
        else $error("end marker without last flag or with a character");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit == itp_pkg::EM_END |=> stack_count_reg == '0 && error_reg == itp_pkg::ST_OK)
        else $error("state not cleared after end marker");

    // Ordinary results carry a zero status.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_end_reg |-> out_status_reg == itp_pkg::ST_OK)
        else $error("status set on an ordinary result");

endmodule

// File: design/itp_ctrl.sv
// ============================================================================
// itp_ctrl: sequencer of the infix to postfix converter
// Walks each accepted character through operand output, operator stack
// pops and pushes, the end-of-expression flush and the end marker.
// ============================================================================
module itp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  itp_pkg::itp_status_t status,
    output itp_pkg::itp_cmd_t    cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHAR  = 7'b0000010,
        S_POP   = 7'b0000100,
        S_TAIL  = 7'b0001000,
        S_FLUSH = 7'b0010000,
        S_END   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next       = state_reg;
        cmd.latch        = 1'b0;
        cmd.set_err      = 1'b0;
        cmd.emit         = itp_pkg::EM_NONE;
        cmd.push         = 1'b0;
        cmd.drop         = 1'b0;
        cmd.reset_state  = 1'b0;
        cmd.flush_pend   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_CHAR;
                end
            end
            // First step of a character: errors end it at once.
            S_CHAR:
            begin
                if (status.err_active || status.pred_err)
                begin
                    cmd.set_err = 1'b1;
                    state_next  = status.last ? S_END : S_IDLE;
                end
                else if (status.cls == itp_pkg::CLS_OPERAND)
                begin
                    cmd.emit   = itp_pkg::EM_CHAR;
                    state_next = S_TAIL;
                end
                else
                begin
                    if (status.in_operand)
                        cmd.emit = itp_pkg::EM_SPACE;
                    state_next = (status.cls == itp_pkg::CLS_SPACE) ? S_TAIL : S_POP;
                end
            end
            // Pop operators, then push or drop the open parenthesis.
            S_POP:
            begin
                if (status.cls != itp_pkg::CLS_OPEN && status.pop_ok)
                begin
                    if (status.can_emit)
                        cmd.emit = itp_pkg::EM_POP;
                end
                else
                begin
                    if (status.cls == itp_pkg::CLS_CLOSE)
                        cmd.drop = 1'b1;
                    else
                        cmd.push = 1'b1;
                    state_next = S_TAIL;
                end
            end
            // On the last character, close an open operand run.
            S_TAIL:
            begin
                if (!status.last)
                    state_next = S_DONE;
                else if (status.in_operand)
                begin
                    if (status.can_emit)
                        cmd.emit = itp_pkg::EM_SPACE;
                end
                else
                    state_next = S_FLUSH;
            end
            // Empty the operator stack.
            S_FLUSH:
            begin
                if (status.stack_empty)
                    state_next = S_END;
                else if (status.can_emit)
                    cmd.emit = itp_pkg::EM_POP;
            end
            // Emit the end marker and clear the expression state.
            S_END:
            begin
                if (status.can_emit)
                begin
                    cmd.emit        = itp_pkg::EM_END;
                    cmd.reset_state = 1'b1;
                    state_next      = S_DONE;
                end
            end
            // Release the final result of the character with its last flag.
            S_DONE:
            begin
                if (status.flush_ok)
                begin
                    cmd.flush_pend = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // A character is taken only when the previous one has fully finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_CHAR)
        else $error("accepted character did not start processing");

    // Stack operations only happen in the pop state.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push || cmd.drop |-> state_reg == S_POP)
        else $error("stack push or drop outside the pop state");

    // The pending result is released only on the way back to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush_pend |=> state_reg == S_IDLE)
        else $error("pending result released mid character");

endmodule

// File: design/infix_to_postfix_converter.sv
// ============================================================================
// infix_to_postfix_converter: shunting-yard infix to postfix conversion
// Controller and datapath joined by command and status structs.
// ============================================================================
// Usage:
// in_ch takes one expression character per transaction, with is_last set on
// the final character. out_ch gives the postfix characters: operands pass
// through, a space closes each operand run, operators leave in precedence
// order. The item marked is_last is followed by an end marker (zero
// character, expr_end set) whose status reports an unmatched ')', an
// unclosed '(' or an operator stack overflow; after an error the rest of the
// expression gives no output but the end marker. last_of_run marks the final
// result caused by each input transaction.
// Sequence: a character is taken in the idle cycle and classified in the next;
// an operand or space then passes the tail and done states, an operator or
// parenthesis first pops each operator it may pop, then is pushed or dropped.
// The last character also closes an open operand run, flushes every operator
// left on the stack and then emits the end marker. An item that raises or
// follows an error goes straight back to idle, or to the end marker if last.
// The output register and a one-result pending stage decouple the sinks;
// when the receiver stalls, the sequencer holds in place with no loss.
// Reset clears the stack count, the error state and both channels at once.
// ============================================================================
module infix_to_postfix_converter (
    input  logic        clk,
    input  logic        rst_n,
    itp_in_if.sink      in_ch,
    itp_out_if.source   out_ch
);

    itp_pkg::itp_cmd_t    cmd;
    itp_pkg::itp_status_t status;
    logic                 in_ready;

    assign in_ch.ready = in_ready;

    itp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    itp_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_char (in_ch.in_char),
        .is_last (in_ch.is_last),
        .cmd     (cmd),
        .status  (status),
        .out_ch  (out_ch)
    );

endmodule
